>>> design/erle_pkg.sv
`default_nettype none

package erle_pkg;

  // coordinate and angle formats
  localparam int COORD_WIDTH = 24;
  localparam int ANGLE_WIDTH = 16;
  localparam int QUARTER_BITS = ANGLE_WIDTH - 2;

  // sine and cosine: signed q14, covers -1.0 to +1.0
  localparam int TRIG_FRAC = 14;
  localparam int TRIG_WIDTH = TRIG_FRAC + 2;
  localparam int NUM_TRIG = 6;

  // quarter-wave series datapath
  localparam int X_WIDTH = 17;   // q16 position within the quarter, up to 1.0
  localparam int P_WIDTH = 31;   // q30 horner accumulator
  localparam int MUL_WIDTH = X_WIDTH + P_WIDTH;

  // rotation datapath
  localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
  localparam int RND_WIDTH = PROD_WIDTH - TRIG_FRAC;
  localparam int SUM_WIDTH = RND_WIDTH + 1;
  localparam int NUM_LANES = 2;
  localparam int LANE_STAGES = 6;  // two per plane rotation
  localparam int LATENCY = LANE_STAGES + 1;

  // register map
  localparam int NUM_REGS = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = $clog2(4 * NUM_REGS);
  localparam int REG_IDX_WIDTH = APB_ADDR_WIDTH - 2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ANGLE_X = REG_IDX_WIDTH'(0);
  localparam logic [REG_IDX_WIDTH-1:0] REG_ANGLE_Y = REG_IDX_WIDTH'(1);
  localparam logic [REG_IDX_WIDTH-1:0] REG_ANGLE_Z = REG_IDX_WIDTH'(2);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [TRIG_WIDTH-1:0] trig_val_t;
  typedef logic [NUM_REGS-1:0][ANGLE_WIDTH-1:0] angles_t;

  typedef struct packed {
    trig_val_t cos_x;
    trig_val_t sin_x;
    trig_val_t cos_y;
    trig_val_t sin_y;
    trig_val_t cos_z;
    trig_val_t sin_z;
  } trig_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // odd series coefficients of sin(pi/2 * x), q30
  function automatic logic [P_WIDTH-1:0] series_coef(input logic [2:0] k);
    logic [P_WIDTH-1:0] c;
    case (k)
      3'd0: c = P_WIDTH'(1686629713);
      3'd1: c = P_WIDTH'(693598668);
      3'd2: c = P_WIDTH'(85569306);
      3'd3: c = P_WIDTH'(5026995);
      3'd4: c = P_WIDTH'(172272);
      default: c = '0;
    endcase
    return c;
  endfunction

  // round a q14-scaled product back to the q0 coordinate scale, half up via floor
  function automatic logic signed [RND_WIDTH-1:0] round_q14(
    input logic signed [PROD_WIDTH-1:0] prod
  );
    logic signed [PROD_WIDTH-1:0] biased;
    biased = prod + (PROD_WIDTH'(1) << (TRIG_FRAC - 1));
    return biased[PROD_WIDTH-1:TRIG_FRAC];
  endfunction

  // clamp to the coordinate range
  function automatic coord_t saturate(input logic signed [SUM_WIDTH-1:0] v);
    coord_t r;
    if ((&v[SUM_WIDTH-1:COORD_WIDTH-1]) || ~(|v[SUM_WIDTH-1:COORD_WIDTH-1])) begin
      r = v[COORD_WIDTH-1:0];
    end else if (v[SUM_WIDTH-1]) begin
      r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  // round both products, add or subtract, saturate
  function automatic coord_t combine(
    input logic signed [PROD_WIDTH-1:0] a,
    input logic signed [PROD_WIDTH-1:0] b,
    input logic sub
  );
    logic signed [RND_WIDTH-1:0] ra;
    logic signed [RND_WIDTH-1:0] rb;
    logic signed [SUM_WIDTH-1:0] s;
    ra = round_q14(a);
    rb = round_q14(b);
    if (sub) begin
      s = {ra[RND_WIDTH-1], ra} - {rb[RND_WIDTH-1], rb};
    end else begin
      s = {ra[RND_WIDTH-1], ra} + {rb[RND_WIDTH-1], rb};
    end
    return saturate(s);
  endfunction

endpackage

`default_nettype wire

>>> design/erle_trig_gen.sv
`default_nettype none

module erle_trig_gen (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             restart_i,
  input  wire erle_pkg::angles_t angles_i,
  output erle_pkg::trig_t       trig_o,
  output logic                  busy_o
);
  import erle_pkg::*;

  localparam int SHL = (QUARTER_BITS <= 16) ? (16 - QUARTER_BITS) : 0;
  localparam int SHR = (QUARTER_BITS > 16) ? (QUARTER_BITS - 16) : 0;
  localparam int R_WIDTH = QUARTER_BITS + 1;
  localparam int XS_WIDTH = R_WIDTH + SHL;
  localparam int MAG_WIDTH = MUL_WIDTH - 32;
  localparam int ONE_Q14 = 1 << TRIG_FRAC;

  localparam logic [2:0] STEP_LOAD = 3'd0;
  localparam logic [2:0] STEP_SQUARE = 3'd1;
  localparam logic [2:0] STEP_FINAL = 3'd6;
  localparam logic [2:0] SERIES_TOP = 3'd4;
  localparam logic [2:0] HORNER_BASE = 3'd5;
  localparam logic [2:0] VAL_LAST = 3'(NUM_TRIG - 1);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q, state_d;
  logic [2:0] val_q, val_d;
  logic [2:0] step_q, step_d;
  logic [X_WIDTH-1:0] x_q, x_d;
  logic [X_WIDTH-1:0] u_q, u_d;
  logic [P_WIDTH-1:0] p_q, p_d;
  logic neg_q, neg_d;
  trig_val_t trig_q [NUM_TRIG];
  logic trig_wr;

  logic [ANGLE_WIDTH-1:0] angle;
  logic [ANGLE_WIDTH-1:0] shifted;
  logic [1:0] quad;
  logic [QUARTER_BITS-1:0] r;
  logic [R_WIDTH-1:0] rr;
  logic [XS_WIDTH-1:0] xs;
  logic [X_WIDTH-1:0] x_new;
  logic [X_WIDTH-1:0] mul_a;
  logic [P_WIDTH-1:0] mul_b;
  logic [MUL_WIDTH-1:0] prod;
  logic [MUL_WIDTH-1:0] prod_rnd;
  logic [MAG_WIDTH-1:0] mag_raw;
  logic [TRIG_WIDTH-1:0] mag;
  trig_val_t trig_new;

  // cosine at even slots is sine a quarter turn on
  assign angle = angles_i[val_q[2:1]];
  assign shifted = val_q[0] ? angle : angle + ANGLE_WIDTH'(1 << QUARTER_BITS);
  assign quad = shifted[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
  assign r = shifted[QUARTER_BITS-1:0];
  assign rr = quad[0] ? R_WIDTH'(1 << QUARTER_BITS) - R_WIDTH'(r) : R_WIDTH'(r);
  assign xs = XS_WIDTH'(rr);
  assign x_new = X_WIDTH'((xs << SHL) >> SHR);

  // shared multiplier operand select
  always_comb begin
    case (step_q)
      STEP_SQUARE: begin
        mul_a = x_q;
        mul_b = P_WIDTH'(x_q);
      end
      STEP_FINAL: begin
        mul_a = x_q;
        mul_b = p_q;
      end
      default: begin
        mul_a = u_q;
        mul_b = p_q;
      end
    endcase
  end

  assign prod = MUL_WIDTH'(mul_a) * MUL_WIDTH'(mul_b);

  // final scaling to q14 with cap at one
  assign prod_rnd = prod + (MUL_WIDTH'(1) << 31);
  assign mag_raw = prod_rnd[MUL_WIDTH-1:32];
  assign mag = (mag_raw > MAG_WIDTH'(ONE_Q14)) ? TRIG_WIDTH'(ONE_Q14) : TRIG_WIDTH'(mag_raw);
  assign trig_new = neg_q ? trig_val_t'(-mag) : trig_val_t'(mag);

  // sequencer over six values, seven steps each
  always_comb begin
    state_d = state_q;
    val_d = val_q;
    step_d = step_q;
    x_d = x_q;
    u_d = u_q;
    p_d = p_q;
    neg_d = neg_q;
    trig_wr = 1'b0;
    case (state_q)
      StIdle: begin
        if (restart_i) begin
          state_d = StRun;
          val_d = '0;
          step_d = STEP_LOAD;
        end
      end
      StRun: begin
        if (restart_i) begin
          val_d = '0;
          step_d = STEP_LOAD;
        end else begin
          case (step_q)
            STEP_LOAD: begin
              x_d = x_new;
              neg_d = quad[1];
              step_d = STEP_SQUARE;
            end
            STEP_SQUARE: begin
              u_d = X_WIDTH'(prod >> 16);
              p_d = series_coef(SERIES_TOP);
              step_d = step_q + 3'd1;
            end
            STEP_FINAL: begin
              trig_wr = 1'b1;
              step_d = STEP_LOAD;
              if (val_q == VAL_LAST) begin
                state_d = StIdle;
              end else begin
                val_d = val_q + 3'd1;
              end
            end
            default: begin
              p_d = series_coef(HORNER_BASE - step_q) - P_WIDTH'(prod >> 16);
              step_d = step_q + 3'd1;
            end
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and trig value store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      val_q <= '0;
      step_q <= STEP_LOAD;
      x_q <= '0;
      u_q <= '0;
      p_q <= '0;
      neg_q <= 1'b0;
      for (int i = 0; i < NUM_TRIG; i++) begin
        trig_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      val_q <= val_d;
      step_q <= step_d;
      x_q <= x_d;
      u_q <= u_d;
      p_q <= p_d;
      neg_q <= neg_d;
      if (trig_wr) begin
        trig_q[val_q] <= trig_new;
      end
    end
  end

  assign busy_o = (state_q == StRun);
  assign trig_o = '{
    cos_x: trig_q[0], sin_x: trig_q[1],
    cos_y: trig_q[2], sin_y: trig_q[3],
    cos_z: trig_q[4], sin_z: trig_q[5]
  };

endmodule

`default_nettype wire

>>> design/erle_plane_rot.sv
`default_nettype none

module erle_plane_rot (
  input  wire logic               clk_i,
  input  wire erle_pkg::coord_t    p_i,
  input  wire erle_pkg::coord_t    q_i,
  input  wire erle_pkg::trig_val_t c_i,
  input  wire erle_pkg::trig_val_t s_i,
  output erle_pkg::coord_t         p_o,
  output erle_pkg::coord_t         q_o
);
  import erle_pkg::*;

  logic signed [PROD_WIDTH-1:0] pc_d, qs_d, ps_d, qc_d;
  logic signed [PROD_WIDTH-1:0] pc_q, qs_q, ps_q, qc_q;
  coord_t p_q, q_q;

  // four products of the plane rotation
  assign pc_d = p_i * c_i;
  assign qs_d = q_i * s_i;
  assign ps_d = p_i * s_i;
  assign qc_d = q_i * c_i;

  always_ff @(posedge clk_i) begin
    pc_q <= pc_d;
    qs_q <= qs_d;
    ps_q <= ps_d;
    qc_q <= qc_d;
  end

  // p' = p*c - q*s, q' = p*s + q*c
  always_ff @(posedge clk_i) begin
    p_q <= combine(pc_q, qs_q, 1'b1);
    q_q <= combine(ps_q, qc_q, 1'b0);
  end

  assign p_o = p_q;
  assign q_o = q_q;

endmodule

`default_nettype wire

>>> design/erle_lane.sv
`default_nettype none

module erle_lane (
  input  wire logic           clk_i,
  input  wire erle_pkg::point_t pt_i,
  input  wire erle_pkg::trig_t  trig_i,
  output erle_pkg::point_t      pt_o
);
  import erle_pkg::*;

  coord_t y1, z1, z2, x2, x3, y3;
  coord_t x_dly_q [2];
  coord_t y_dly_q [2];
  coord_t z_dly_q [2];

  // about x: (y, z) plane
  erle_plane_rot u_rot_x (
    .clk_i (clk_i),
    .p_i   (pt_i.y),
    .q_i   (pt_i.z),
    .c_i   (trig_i.cos_x),
    .s_i   (trig_i.sin_x),
    .p_o   (y1),
    .q_o   (z1)
  );

  // about y: (z, x) plane
  erle_plane_rot u_rot_y (
    .clk_i (clk_i),
    .p_i   (z1),
    .q_i   (x_dly_q[1]),
    .c_i   (trig_i.cos_y),
    .s_i   (trig_i.sin_y),
    .p_o   (z2),
    .q_o   (x2)
  );

  // about z: (x, y) plane
  erle_plane_rot u_rot_z (
    .clk_i (clk_i),
    .p_i   (x2),
    .q_i   (y_dly_q[1]),
    .c_i   (trig_i.cos_z),
    .s_i   (trig_i.sin_z),
    .p_o   (x3),
    .q_o   (y3)
  );

  // untouched coordinate follows each rotation
  always_ff @(posedge clk_i) begin
    x_dly_q[0] <= pt_i.x;
    x_dly_q[1] <= x_dly_q[0];
    y_dly_q[0] <= y1;
    y_dly_q[1] <= y_dly_q[0];
    z_dly_q[0] <= z2;
    z_dly_q[1] <= z_dly_q[0];
  end

  assign pt_o = '{x: x3, y: y3, z: z_dly_q[1]};

endmodule

`default_nettype wire

>>> design/euler_rotate_line_endpoints_core.sv
`default_nettype none

// a segment taken in passes the lane pipeline registers and then the result registers to the result ports
// throughput: one segment per cycle while busy is low, the two endpoints go through two rotation lanes
// results show for one cycle with done_o; the receiver cannot stall
// after reset and after every register write the sine/cosine sequencer runs
// through six values, seven steps each on one shared multiplier, with busy high
// reset clears the angle registers to zero and empties the pipeline

module euler_rotate_line_endpoints_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [erle_pkg::COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [erle_pkg::COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [erle_pkg::COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [erle_pkg::COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [erle_pkg::COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [erle_pkg::COORD_WIDTH-1:0] end_z_i,
  output logic                                        done_o,
  output logic signed [erle_pkg::COORD_WIDTH-1:0]      rot_start_x_o,
  output logic signed [erle_pkg::COORD_WIDTH-1:0]      rot_start_y_o,
  output logic signed [erle_pkg::COORD_WIDTH-1:0]      rot_start_z_o,
  output logic signed [erle_pkg::COORD_WIDTH-1:0]      rot_end_x_o,
  output logic signed [erle_pkg::COORD_WIDTH-1:0]      rot_end_y_o,
  output logic signed [erle_pkg::COORD_WIDTH-1:0]      rot_end_z_o,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [erle_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  wire logic [erle_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [erle_pkg::APB_DATA_WIDTH-1:0]          prdata,
  output logic                                        pready
);
  import erle_pkg::*;

  angles_t angle_q;
  logic wr_en;
  logic [REG_IDX_WIDTH-1:0] reg_idx;
  trig_t trig;
  logic trig_busy;
  logic accept;
  logic [LANE_STAGES-1:0] vld_q;
  point_t lane_in [NUM_LANES];
  point_t lane_out [NUM_LANES];
  point_t rot_q [NUM_LANES];
  logic done_q;

  // register port
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ANGLE_X: angle_q[0] <= pwdata[ANGLE_WIDTH-1:0];
        REG_ANGLE_Y: angle_q[1] <= pwdata[ANGLE_WIDTH-1:0];
        REG_ANGLE_Z: angle_q[2] <= pwdata[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGLE_X: prdata = APB_DATA_WIDTH'(angle_q[0]);
      REG_ANGLE_Y: prdata = APB_DATA_WIDTH'(angle_q[1]);
      REG_ANGLE_Z: prdata = APB_DATA_WIDTH'(angle_q[2]);
      default: prdata = '0;
    endcase
  end

  // sine and cosine, recomputed after each write
  erle_trig_gen u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (wr_en),
    .angles_i  (angle_q),
    .trig_o    (trig),
    .busy_o    (trig_busy)
  );

  assign busy = trig_busy;
  assign accept = start && !trig_busy;

  // one lane per endpoint
  assign lane_in[0] = '{x: start_x_i, y: start_y_i, z: start_z_i};
  assign lane_in[1] = '{x: end_x_i, y: end_y_i, z: end_z_i};

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    erle_lane u_lane (
      .clk_i  (clk_i),
      .pt_i   (lane_in[l]),
      .trig_i (trig),
      .pt_o   (lane_out[l])
    );
  end

  // transfer tracking through the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[LANE_STAGES-2:0], accept};
      done_q <= vld_q[LANE_STAGES-1];
    end
  end

  // merge the lanes into the result registers
  always_ff @(posedge clk_i) begin
    if (vld_q[LANE_STAGES-1]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rot_q[l] <= lane_out[l];
      end
    end
  end

  assign done_o = done_q;
  assign rot_start_x_o = rot_q[0].x;
  assign rot_start_y_o = rot_q[0].y;
  assign rot_start_z_o = rot_q[0].z;
  assign rot_end_x_o = rot_q[1].x;
  assign rot_end_y_o = rot_q[1].y;
  assign rot_end_z_o = rot_q[1].z;

endmodule

`default_nettype wire

>>> design/erle_checker.sv
`default_nettype none

module erle_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               done_o,
  input wire logic                               psel,
  input wire logic                               penable,
  input wire logic                               pwrite,
  input wire logic [erle_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input wire logic [erle_pkg::APB_DATA_WIDTH-1:0] prdata
);
  import erle_pkg::*;

  // every accepted segment gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted segment produced no result");

  // no result without a transfer in
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted segment");

  // a register write holds off new segments while the tables refresh
  a_write_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy)
    else $error("busy low after register write");

  // read data changes only by address or by a write
  a_prdata_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($stable(paddr) && !$past(psel && penable && pwrite)) |-> $stable(prdata))
    else $error("read data changed without write");

endmodule

bind euler_rotate_line_endpoints_core erle_checker u_erle_checker (.*);

`default_nettype wire
